// ===== hw/rtl/lpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and constants for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

  localparam logic [1:0] ST_PAYLOAD  = 2'd0;
  localparam logic [1:0] ST_EOS      = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  localparam logic [6:0]  SEVEN_MASK     = 7'h7F;
  localparam int unsigned MORE_FLAG_BIT  = 7;
  localparam logic [31:0] MAX_LEN_RESET  = 32'd65536;

  localparam int unsigned OUT_TDATA_W = 8;

  // One result word, as produced by the step logic
  typedef struct packed {
    logic       emit;
    logic [1:0] status;
    logic [7:0] data;
    logic       last;
  } lpmd_result_t;

endpackage

// ===== hw/rtl/lpmd_step.sv =====
// ----------------------------------------------------------------------------
// lpmd_step
// Next-state and result logic for one input byte: header accumulate,
// length checks and payload countdown.
// ----------------------------------------------------------------------------
module lpmd_step import lpmd_pkg::*; #(
  parameter int LEN_BITS = 32
) (
  input  logic                in_header,
  input  logic [LEN_BITS-1:0] length_acc,
  input  logic [LEN_BITS-1:0] bytes_left,
  input  logic [31:0]         max_length,
  input  logic [7:0]          data_in,
  output logic                in_header_nxt,
  output logic [LEN_BITS-1:0] length_acc_nxt,
  output logic [LEN_BITS-1:0] bytes_left_nxt,
  output lpmd_result_t        result
);

  localparam int CMP_W = (LEN_BITS > 32) ? LEN_BITS : 32;

  logic                hdr;
  logic                acc_ovf;
  logic [LEN_BITS-1:0] acc_shift;
  logic [LEN_BITS-1:0] bl_dec;
  logic [CMP_W-1:0]    len_ext;
  logic [CMP_W-1:0]    max_ext;

  // payload state with nothing left falls back to header parsing
  assign hdr       = in_header || (bytes_left == '0);
  assign acc_ovf   = |length_acc[LEN_BITS-1:LEN_BITS-7];
  assign acc_shift = {length_acc[LEN_BITS-8:0], data_in[6:0] & SEVEN_MASK};
  assign bl_dec    = bytes_left - LEN_BITS'(1);
  assign len_ext   = CMP_W'(acc_shift);
  assign max_ext   = CMP_W'(max_length);

  always_comb begin
    in_header_nxt  = in_header;
    length_acc_nxt = length_acc;
    bytes_left_nxt = bytes_left;
    result         = '0;
    if (hdr) begin
      in_header_nxt = 1'b1;
      if (acc_ovf) begin
        length_acc_nxt = '0;
        result.emit    = 1'b1;
        result.status  = ST_OVERSIZE;
      end else if (data_in[MORE_FLAG_BIT]) begin
        length_acc_nxt = acc_shift;
      end else begin
        length_acc_nxt = '0;
        if (acc_shift == '0) begin
          result.emit   = 1'b1;
          result.status = ST_EOS;
        end else if (len_ext > max_ext) begin
          result.emit   = 1'b1;
          result.status = ST_OVERSIZE;
        end else begin
          bytes_left_nxt = acc_shift;
          in_header_nxt  = 1'b0;
        end
      end
    end else begin
      bytes_left_nxt = bl_dec;
      result.emit    = 1'b1;
      result.status  = ST_PAYLOAD;
      result.data    = data_in;
      if (bl_dec == '0) begin
        in_header_nxt  = 1'b1;
        length_acc_nxt = '0;
        result.last    = 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/length_prefixed_message_deframer_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_core
// Splits a byte stream into messages framed by a big-endian base-128 length
// header; passes payload bytes out and reports end of stream and oversize.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | contents
//  in_     | in  | in_tvalid/in_tready   | tdata[7:0] raw stream byte
//  out_    | out | out_tvalid/out_tready | tuser[1:0] status, tdata[7:0] byte; tlast
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_data[31:0] max_length
//
// One word per cycle unless out_ stalls; each byte is handled combinationally by
// the step logic and its result is presented on out_ the cycle after acceptance.
// Input is taken while the output register is empty or being drained.
// Reset (rst_n low, synchronous) enters header parsing, max_length = 65536.
// An output stall holds the result word and stops input acceptance.
module length_prefixed_message_deframer_core import lpmd_pkg::*; #(
  parameter int LEN_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,    // [7:0] in_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [7:0] out_byte
  output logic [1:0]             out_tuser,   // [1:0] out_status
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [31:0]            cfg_data
);

  logic                in_header_r;
  logic                in_header_nxt;
  logic [LEN_BITS-1:0] length_acc_r;
  logic [LEN_BITS-1:0] length_acc_nxt;
  logic [LEN_BITS-1:0] bytes_left_r;
  logic [LEN_BITS-1:0] bytes_left_nxt;
  logic [31:0]         max_length_r;
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [7:0]          out_byte_r;
  logic                out_last_r;
  lpmd_result_t        result;
  logic                in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  lpmd_step #(.LEN_BITS(LEN_BITS)) u_step (
    .in_header      (in_header_r),
    .length_acc     (length_acc_r),
    .bytes_left     (bytes_left_r),
    .max_length     (max_length_r),
    .data_in        (in_tdata),
    .in_header_nxt  (in_header_nxt),
    .length_acc_nxt (length_acc_nxt),
    .bytes_left_nxt (bytes_left_nxt),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_header_r  <= 1'b1;
      length_acc_r <= '0;
      bytes_left_r <= '0;
      max_length_r <= MAX_LEN_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_length_r <= cfg_data;
      end
      if (in_acc) begin
        in_header_r  <= in_header_nxt;
        length_acc_r <= length_acc_nxt;
        bytes_left_r <= bytes_left_nxt;
        out_valid_r  <= result.emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && result.emit) begin
      out_status_r <= result.status;
      out_byte_r   <= result.data;
      out_last_r   <= result.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/lpmd_checker.sv =====
// ----------------------------------------------------------------------------
// lpmd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module lpmd_checker import lpmd_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]             out_tuser,
  input logic                   out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_PAYLOAD || out_tuser == ST_EOS ||
                    out_tuser == ST_OVERSIZE))
    else $error("unknown status code");

  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == ST_PAYLOAD)
    else $error("last mark on a non-payload word");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_PAYLOAD |-> out_tdata == 8'd0 && !out_tlast)
    else $error("status word carries data");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready) && !out_tvalid |=> !out_tvalid)
    else $error("result word without an accepted input word");

endmodule

bind length_prefixed_message_deframer_core lpmd_checker u_lpmd_checker (.*);
